// ===== src/ssq_pkg.sv =====
// Shared types and constants for the scripted stimulus sequencer.
// No dependencies; the top, remainder unit, key store, checker and testbench import it.
package ssq_pkg;

  localparam int CmdW   = 2;
  localparam int IdxW   = 8;
  localparam int KindW  = 3;
  localparam int AmtW   = 24;
  localparam int BtnW   = 16;
  localparam int DirW   = 3;
  localparam int KeyW   = 4;
  localparam int ValW   = 16;
  localparam int CntW   = 9;
  localparam int PerW   = 17;
  localparam int StickW = 8;

  // table depth, tied to the step index and step count widths
  localparam int MaxSteps = 256;

  localparam int InDataW  = 96;
  localparam int OutDataW = 64;

  localparam logic [PerW-1:0]   DefPeriod = 17'd60;
  localparam logic [AmtW-1:0]   DefLimit  = 24'd5400;
  localparam logic [AmtW-1:0]   PeriodMax = 24'd100000;
  localparam logic [AmtW-1:0]   LimitMax  = 24'd10000000;
  localparam logic [StickW-1:0] StickPos  = 8'd72;
  localparam logic [StickW-1:0] StickNeg  = 8'd184;  // -72

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_ARM   = 2'd1,
    CMD_EVENT = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    K_WAIT        = 3'd0,
    K_PRESS       = 3'd1,
    K_STICK       = 3'd2,
    K_WAITEV      = 3'd3,
    K_PRESSUNTIL  = 3'd4,
    K_SETPERIOD   = 3'd5,
    K_SETTIMEOUT  = 3'd6,
    K_NOP         = 3'd7
  } kind_e;

  typedef enum logic [DirW-1:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  // input item payload, step_index in the lowest bits and pad in the highest
  typedef struct packed {
    logic            pad;
    logic [ValW-1:0] event_value;
    logic [KeyW-1:0] event_key;
    logic [ValW-1:0] step_value;
    logic            step_has_value;
    logic [KeyW-1:0] step_key;
    logic [DirW-1:0] step_stick_dir;
    logic [BtnW-1:0] step_buttons;
    logic [AmtW-1:0] step_amount;
    logic [KindW-1:0] step_kind;
    logic [IdxW-1:0] step_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        pad;
    logic              script_running;
    logic              script_done;
    logic [AmtW-1:0]   wait_elapsed;
    logic              wait_timed_out;
    logic              wait_satisfied;
    logic              wait_entered;
    logic [StickW-1:0] stick_y;
    logic [StickW-1:0] stick_x;
    logic [BtnW-1:0]   buttons;
  } out_item_t;

  // one table entry as held in the step memory
  typedef struct packed {
    logic [ValW-1:0]  value;
    logic             has_value;
    logic [KeyW-1:0]  key;
    logic [BtnW-1:0]  buttons;
    logic [DirW-1:0]  dir;
    logic [AmtW-1:0]  amount;
    logic [KindW-1:0] kind;
  } step_t;

  typedef struct packed {
    logic            start;
    logic [AmtW-1:0] dividend;
    logic [PerW-1:0] divisor;
  } rem_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } rem_rsp_t;

endpackage

// ===== src/scripted_stimulus_sequencer_top.sv =====
// Top level of the scripted stimulus sequencer: stream ports, step sequencer.
// Depends on ssq_pkg, ssq_ram, ssq_rem and ssq_keys.

// Load and arm items are handled in the idle state; an event item passes through
// the fetch and execute states. A tick item walks the steps, up to a full
// 256-entry table, as the sequencer reads one step from the step memory per
// cycle; a press-until step may wait on the bit-serial repeat-period remainder.
// One result item comes out per tick, from an output register, so the next item
// is taken while it waits.
// The step memory has no reset: only slots that were loaded may be run.
module scripted_stimulus_sequencer_top #(
  parameter int KEY_COUNT = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // step_index, step_kind, step_amount, step_buttons, step_stick_dir,
  // step_key, step_has_value, step_value, event_key, event_value, zero pad
  input  logic [ssq_pkg::InDataW-1:0]     s_axis_tdata,
  // command
  input  logic [ssq_pkg::CmdW-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // buttons, stick_x, stick_y, wait_entered, wait_satisfied, wait_timed_out,
  // wait_elapsed, script_done, script_running, zero pad
  output logic [ssq_pkg::OutDataW-1:0]    m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [ssq_pkg::CntW-1:0]        cfg_wdata_i
);
  import ssq_pkg::*;

  localparam int AddrW = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_EXEC  = 6'b000100,
    S_MOD   = 6'b001000,
    S_END   = 6'b010000,
    S_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  cmd_e   cmd_q, cmd_d;

  logic [CntW-1:0]   step_count_q, count;
  logic [CntW-1:0]   cursor_q, cursor_d;
  logic [AmtW-1:0]   wait_left_q, wait_left_d;
  logic              running_q, running_d;
  logic              wait_open_q, wait_open_d;
  logic              fired_q, fired_d;
  logic [AmtW-1:0]   elapsed_q, elapsed_d, elapsed_n, wl;
  logic [PerW-1:0]   period_q, period_d;
  logic [AmtW-1:0]   limit_q, limit_d;

  // per-tick accumulators
  logic [BtnW-1:0]   pressed_q, pressed_d;
  logic [StickW-1:0] sx_q, sx_d, sy_q, sy_d;
  logic              entered_q, entered_d, sat_q, sat_d, to_q, to_d;
  logic              touched_q, touched_d, done_q, done_d;

  logic [KeyW-1:0]   ev_key_q, ev_key_d;
  logic [ValW-1:0]   ev_val_q, ev_val_d;
  logic [BtnW-1:0]   mod_btn_q, mod_btn_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;

  in_item_t          in_item;
  step_t             wstep, step;
  logic              s_fire, ram_we, key_we, key_ok, key_hit, in_table;
  logic              entering, ok;
  rem_req_t          rem_req;
  rem_rsp_t          rem_rsp;

  assign in_item = in_item_t'(s_axis_tdata);
  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  assign count = (int'(step_count_q) > MaxSteps) ? CntW'(MaxSteps) : step_count_q;
  assign in_table = running_q && (cursor_q < count);

  assign wstep.value     = in_item.step_value;
  assign wstep.has_value = in_item.step_has_value;
  assign wstep.key       = in_item.step_key;
  assign wstep.buttons   = in_item.step_buttons;
  assign wstep.dir       = in_item.step_stick_dir;
  assign wstep.amount    = in_item.step_amount;
  assign wstep.kind      = in_item.step_kind;

  ssq_ram #(
    .Width ($bits(step_t)),
    .Depth (MaxSteps)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AddrW'(in_item.step_index)),
    .wdata_i (wstep),
    .raddr_i (AddrW'(cursor_d)),
    .rdata_o (step)
  );

  ssq_keys #(
    .KEY_COUNT (KEY_COUNT)
  ) u_keys (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .we_i      (key_we),
    .wkey_i    (ev_key_q),
    .wvalue_i  (ev_val_q),
    .wkey_ok_o (key_ok),
    .lkey_i    (step.key),
    .lvalue_i  (step.value),
    .hit_o     (key_hit)
  );

  ssq_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .rsp_o  (rem_rsp)
  );

  assign entering  = !wait_open_q;
  assign ok        = step.has_value ? key_hit : (!entering && fired_q);
  assign elapsed_n = entering ? AmtW'(1) : (elapsed_q + 1'b1);
  assign wl        = (wait_left_q == '0) ? step.amount : wait_left_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cursor_d    = cursor_q;
    wait_left_d = wait_left_q;
    running_d   = running_q;
    wait_open_d = wait_open_q;
    fired_d     = fired_q;
    elapsed_d   = elapsed_q;
    period_d    = period_q;
    limit_d     = limit_q;
    pressed_d   = pressed_q;
    sx_d        = sx_q;
    sy_d        = sy_q;
    entered_d   = entered_q;
    sat_d       = sat_q;
    to_d        = to_q;
    touched_d   = touched_q;
    done_d      = done_q;
    ev_key_d    = ev_key_q;
    ev_val_d    = ev_val_q;
    mod_btn_d   = mod_btn_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d       = out_q;
    ram_we      = 1'b0;
    key_we      = 1'b0;
    rem_req     = '0;

    case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cmd_d = cmd_e'(s_axis_tuser);
          case (cmd_e'(s_axis_tuser))
            CMD_LOAD: begin
              ram_we = (int'(in_item.step_index) < MaxSteps);
            end
            CMD_ARM: begin
              cursor_d    = '0;
              wait_left_d = '0;
              wait_open_d = 1'b0;
              fired_d     = 1'b0;
              elapsed_d   = '0;
              period_d    = DefPeriod;
              limit_d     = DefLimit;
              running_d   = (count != '0);
            end
            CMD_EVENT: begin
              ev_key_d = in_item.event_key;
              ev_val_d = in_item.event_value;
              state_d  = S_FETCH;
            end
            CMD_TICK: begin
              pressed_d = '0;
              sx_d      = '0;
              sy_d      = '0;
              entered_d = 1'b0;
              sat_d     = 1'b0;
              to_d      = 1'b0;
              touched_d = 1'b0;
              done_d    = 1'b0;
              state_d   = S_FETCH;
            end
            default: ;
          endcase
        end
      end

      S_FETCH: state_d = S_EXEC;

      S_EXEC: begin
        if (cmd_q == CMD_EVENT) begin
          // step data is the entry under the cursor
          key_we = 1'b1;
          if (key_ok && wait_open_q && (int'(cursor_q) < MaxSteps) &&
              (step.key == ev_key_q)) begin
            fired_d = 1'b1;
          end
          state_d = S_IDLE;
        end else if (!in_table) begin
          state_d = S_END;
        end else begin
          case (kind_e'(step.kind))
            K_WAIT: begin
              if ((wait_left_q == '0) && (step.amount == '0)) begin
                cursor_d = cursor_q + 1'b1;
              end else begin
                wait_left_d = wl - 1'b1;
                if (wl == AmtW'(1)) begin
                  cursor_d = cursor_q + 1'b1;
                end
                state_d = S_END;
              end
            end
            K_PRESS: begin
              pressed_d = pressed_q | step.buttons;
              cursor_d  = cursor_q + 1'b1;
            end
            K_STICK: begin
              sx_d = '0;
              sy_d = '0;
              case (dir_e'(step.dir))
                DIR_UP:    sy_d = StickPos;
                DIR_DOWN:  sy_d = StickNeg;
                DIR_LEFT:  sx_d = StickNeg;
                DIR_RIGHT: sx_d = StickPos;
                default: ;
              endcase
              cursor_d = cursor_q + 1'b1;
            end
            K_WAITEV, K_PRESSUNTIL: begin
              touched_d = 1'b1;
              if (entering) begin
                wait_open_d = 1'b1;
                fired_d     = 1'b0;
                elapsed_d   = '0;
                entered_d   = 1'b1;
                if (step.kind == K_PRESSUNTIL) begin
                  pressed_d = pressed_q | step.buttons;
                end
              end
              if (ok) begin
                sat_d       = 1'b1;
                wait_open_d = 1'b0;
                cursor_d    = cursor_q + 1'b1;
                state_d     = S_END;
              end else begin
                elapsed_d = elapsed_n;
                if (elapsed_n >= limit_q) begin
                  to_d        = 1'b1;
                  wait_open_d = 1'b0;
                  cursor_d    = cursor_q + 1'b1;
                end
                if ((step.kind == K_PRESSUNTIL) && (period_q != '0)) begin
                  // repeat press when elapsed is a multiple of the period
                  rem_req.start    = 1'b1;
                  rem_req.dividend = elapsed_n;
                  rem_req.divisor  = period_q;
                  mod_btn_d        = step.buttons;
                  state_d          = S_MOD;
                end else begin
                  state_d = S_END;
                end
              end
            end
            K_SETPERIOD: begin
              period_d = (step.amount > PeriodMax) ? PeriodMax[PerW-1:0]
                                                   : step.amount[PerW-1:0];
              cursor_d = cursor_q + 1'b1;
            end
            K_SETTIMEOUT: begin
              limit_d  = (step.amount > LimitMax) ? LimitMax : step.amount;
              cursor_d = cursor_q + 1'b1;
            end
            default: cursor_d = cursor_q + 1'b1;
          endcase
        end
      end

      S_MOD: begin
        if (rem_rsp.done) begin
          if (rem_rsp.zero) begin
            pressed_d = pressed_q | mod_btn_q;
          end
          state_d = S_END;
        end
      end

      S_END: begin
        if (running_q && (cursor_q >= count)) begin
          running_d = 1'b0;
          done_d    = 1'b1;
        end
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d          = 1'b1;
          out_d.pad            = '0;
          out_d.buttons        = pressed_q;
          out_d.stick_x        = sx_q;
          out_d.stick_y        = sy_q;
          out_d.wait_entered   = entered_q;
          out_d.wait_satisfied = sat_q;
          out_d.wait_timed_out = to_q;
          out_d.wait_elapsed   = touched_q ? elapsed_q : '0;
          out_d.script_done    = done_q;
          out_d.script_running = running_q;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= CMD_LOAD;
      step_count_q <= '0;
      cursor_q     <= '0;
      wait_left_q  <= '0;
      running_q    <= 1'b0;
      wait_open_q  <= 1'b0;
      fired_q      <= 1'b0;
      elapsed_q    <= '0;
      period_q     <= DefPeriod;
      limit_q      <= DefLimit;
      pressed_q    <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      entered_q    <= 1'b0;
      sat_q        <= 1'b0;
      to_q         <= 1'b0;
      touched_q    <= 1'b0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      step_count_q <= cfg_we_i ? cfg_wdata_i : step_count_q;
      cursor_q     <= cursor_d;
      wait_left_q  <= wait_left_d;
      running_q    <= running_d;
      wait_open_q  <= wait_open_d;
      fired_q      <= fired_d;
      elapsed_q    <= elapsed_d;
      period_q     <= period_d;
      limit_q      <= limit_d;
      pressed_q    <= pressed_d;
      sx_q         <= sx_d;
      sy_q         <= sy_d;
      entered_q    <= entered_d;
      sat_q        <= sat_d;
      to_q         <= to_d;
      touched_q    <= touched_d;
      done_q       <= done_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_key_q  <= ev_key_d;
    ev_val_q  <= ev_val_d;
    mod_btn_q <= mod_btn_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== src/ssq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ssq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/ssq_rem.sv =====
// Bit-serial remainder unit: one restoring step per cycle for each dividend bit.
// Depends on ssq_pkg.
module ssq_rem (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ssq_pkg::rem_req_t req_i,
  output ssq_pkg::rem_rsp_t rsp_o
);
  import ssq_pkg::*;

  localparam int CntBits = $clog2(AmtW);

  logic               busy_q, done_q;
  logic [CntBits-1:0] cnt_q;
  logic [AmtW-1:0]    num_q;
  logic [PerW-1:0]    div_q, rem_q;
  logic [PerW:0]      trial, diff;

  assign trial = {rem_q, num_q[AmtW-1]};
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntBits'(AmtW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      div_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[AmtW-2:0], 1'b0};
      // borrow out of the trial subtract means the divisor did not fit
      rem_q <= diff[PerW] ? trial[PerW-1:0] : diff[PerW-1:0];
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.zero = (rem_q == '0);

endmodule

// ===== src/ssq_keys.sv =====
// Event key store: latest value and seen flag per key, plus value-match lookup.
// Depends on ssq_pkg.
module ssq_keys #(
  parameter int KEY_COUNT = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [ssq_pkg::KeyW-1:0] wkey_i,
  input  logic [ssq_pkg::ValW-1:0] wvalue_i,
  output logic                   wkey_ok_o,
  input  logic [ssq_pkg::KeyW-1:0] lkey_i,
  input  logic [ssq_pkg::ValW-1:0] lvalue_i,
  output logic                   hit_o
);
  import ssq_pkg::*;

  // only keys that fit the key field can ever be stored
  localparam int KeyNum = (KEY_COUNT < (1 << KeyW)) ? KEY_COUNT : (1 << KeyW);
  localparam int KeyIdxW = (KeyNum > 1) ? $clog2(KeyNum) : 1;

  logic [ValW-1:0]   val_q [KeyNum];
  logic [KeyNum-1:0] seen_q;
  logic              lkey_ok;
  logic [KeyIdxW-1:0] widx, lidx;

  assign wkey_ok_o = (int'(wkey_i) < KEY_COUNT);
  assign lkey_ok   = (int'(lkey_i) < KEY_COUNT);
  assign widx      = KeyIdxW'(wkey_i);
  assign lidx      = KeyIdxW'(lkey_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      for (int i = 0; i < KeyNum; i++) begin
        val_q[i] <= '0;
      end
    end else if (we_i && wkey_ok_o) begin
      seen_q[widx] <= 1'b1;
      val_q[widx]  <= wvalue_i;
    end
  end

  assign hit_o = lkey_ok && seen_q[lidx] && (val_q[lidx] == lvalue_i);

endmodule

// ===== src/ssq_chk.sv =====
// Port-level checker for the scripted stimulus sequencer, bound to the top.
// Depends on ssq_pkg.
module ssq_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic [ssq_pkg::CmdW-1:0]     s_axis_tuser,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [ssq_pkg::OutDataW-1:0] m_axis_tdata
);
  import ssq_pkg::*;

  out_item_t o;
  assign o = out_item_t'(m_axis_tdata);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result item changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK) |=> !s_axis_tready)
    else $error("tick item did not occupy the sequencer");

  a_done_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(o.script_done && o.script_running))
    else $error("script both done and running");

  a_wait_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(o.wait_satisfied && o.wait_timed_out))
    else $error("wait both satisfied and timed out");

  a_stick_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (o.stick_x == '0) || (o.stick_y == '0))
    else $error("stick tilted on both axes");

endmodule

bind scripted_stimulus_sequencer_top ssq_chk u_ssq_chk (.*);

// ===== tb/sv/tb_scripted_stimulus_sequencer_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for scripted_stimulus_sequencer_top: drives load, arm,
// event and tick items, predicts every tick result and checks it field by field.
// Depends on ssq_pkg and the RTL of the block.
module tb_scripted_stimulus_sequencer_top;
  import ssq_pkg::*;

  localparam int ItemTarget   = 1300;
  localparam int WdogLimit    = 6000;
  localparam int HoldCycles   = 400;
  localparam int SettleCycles = 300;
  localparam int TableDepth   = 256;
  localparam int MaxReports   = 60;

  localparam logic [DirW-1:0] DIR_BOGUS = 3'd7;

  // Tick predictor and the queue of tick results still due.
  class tick_scoreboard;
    step_t           tbl [TableDepth];
    logic [CntW-1:0] step_cnt;
    int unsigned     cur;
    logic [AmtW-1:0] wait_left;
    bit              running;
    bit              wait_open;
    bit              fired;
    logic [AmtW-1:0] elap;
    logic [AmtW-1:0] period;
    logic [AmtW-1:0] limit;
    logic [ValW-1:0] key_val [16];
    bit              key_seen [16];
    out_item_t       tick_due [$];
    int unsigned     errors, results, n_ticks, n_met, n_timeout, n_finished;

    function new();
      foreach (tbl[i]) tbl[i] = '0;
      foreach (key_val[i]) begin
        key_val[i]  = '0;
        key_seen[i] = 1'b0;
      end
      step_cnt = '0;
      running  = 1'b0;
      clear_run();
    endfunction

    function void clear_run();
      cur       = 0;
      wait_left = '0;
      wait_open = 1'b0;
      fired     = 1'b0;
      elap      = '0;
      period    = AmtW'(DefPeriod);
      limit     = DefLimit;
    endfunction

    function int unsigned active_steps();
      return (step_cnt > 9'd256) ? TableDepth : int'(step_cnt);
    endfunction

    function void set_steps(logic [CntW-1:0] v);
      step_cnt = v;
    endfunction

    function int unsigned pending();
      return tick_due.size();
    endfunction

    // key and value of the step the script is sitting on, if any
    function bit peek_step(output logic [KeyW-1:0] k, output logic [ValW-1:0] v);
      k = '0;
      v = '0;
      if (!running || cur >= active_steps()) return 1'b0;
      k = tbl[cur].key;
      v = tbl[cur].value;
      return 1'b1;
    endfunction

    function void predict_tick();
      out_item_t   r;
      step_t       s;
      int unsigned n;
      bit          stop, ok, touched;
      r       = '0;
      stop    = 1'b0;
      touched = 1'b0;
      n       = active_steps();
      while (running && cur < n && !stop) begin
        s = tbl[cur];
        case (s.kind)
          K_WAIT: begin
            if (wait_left == 0 && s.amount == 0) begin
              cur++;
            end else begin
              if (wait_left == 0) wait_left = s.amount;
              wait_left--;
              if (wait_left == 0) cur++;
              stop = 1'b1;
            end
          end
          K_PRESS: begin
            r.buttons |= s.buttons;
            cur++;
          end
          K_STICK: begin
            r.stick_x = '0;
            r.stick_y = '0;
            case (s.dir)
              DIR_UP:    r.stick_y = StickPos;
              DIR_DOWN:  r.stick_y = StickNeg;
              DIR_LEFT:  r.stick_x = StickNeg;
              DIR_RIGHT: r.stick_x = StickPos;
              default:   ;
            endcase
            cur++;
          end
          K_WAITEV, K_PRESSUNTIL: begin
            touched = 1'b1;
            if (!wait_open) begin
              wait_open      = 1'b1;
              fired          = 1'b0;
              elap           = '0;
              r.wait_entered = 1'b1;
              if (s.kind == K_PRESSUNTIL) r.buttons |= s.buttons;
            end
            if (s.has_value) ok = key_seen[s.key] && key_val[s.key] == s.value;
            else ok = fired;
            if (ok) begin
              r.wait_satisfied = 1'b1;
              wait_open        = 1'b0;
              cur++;
            end else begin
              elap = elap + 1'b1;
              if (s.kind == K_PRESSUNTIL && period != 0 && (elap % period) == 0)
                r.buttons |= s.buttons;
              if (elap >= limit) begin
                r.wait_timed_out = 1'b1;
                wait_open        = 1'b0;
                cur++;
              end
            end
            stop = 1'b1;
          end
          K_SETPERIOD: begin
            period = (s.amount > PeriodMax) ? PeriodMax : s.amount;
            cur++;
          end
          K_SETTIMEOUT: begin
            limit = (s.amount > LimitMax) ? LimitMax : s.amount;
            cur++;
          end
          default: cur++;
        endcase
      end
      if (running && cur >= n) begin
        running       = 1'b0;
        r.script_done = 1'b1;
      end
      r.wait_elapsed   = touched ? elap : '0;
      r.script_running = running;
      n_ticks++;
      n_met      += r.wait_satisfied;
      n_timeout  += r.wait_timed_out;
      n_finished += r.script_done;
      tick_due.push_back(r);
    endfunction

    function void take_item(cmd_e c, in_item_t d);
      case (c)
        CMD_LOAD: begin
          tbl[d.step_index] = '{value: d.step_value, has_value: d.step_has_value,
                                key: d.step_key, buttons: d.step_buttons,
                                dir: d.step_stick_dir, amount: d.step_amount,
                                kind: d.step_kind};
        end
        CMD_ARM: begin
          clear_run();
          running = active_steps() > 0;
        end
        CMD_EVENT: begin
          key_val[d.event_key]  = d.event_value;
          key_seen[d.event_key] = 1'b1;
          if (wait_open && cur < TableDepth && tbl[cur].key == d.event_key) fired = 1'b1;
        end
        default: predict_tick();
      endcase
    endfunction

    function void compare_field(string name, logic [AmtW-1:0] want, logic [AmtW-1:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: tick result %0d, %s: expected 0x%0h, got 0x%0h",
                   $time, results, name, want, got);
      end
    endfunction

    function void check_tick(out_item_t got);
      out_item_t want;
      if (tick_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected tick result 0x%0h", $time, got);
        return;
      end
      want = tick_due.pop_front();
      compare_field("buttons", want.buttons, got.buttons);
      compare_field("stick_x", want.stick_x, got.stick_x);
      compare_field("stick_y", want.stick_y, got.stick_y);
      compare_field("wait_entered", want.wait_entered, got.wait_entered);
      compare_field("wait_satisfied", want.wait_satisfied, got.wait_satisfied);
      compare_field("wait_timed_out", want.wait_timed_out, got.wait_timed_out);
      compare_field("wait_elapsed", want.wait_elapsed, got.wait_elapsed);
      compare_field("script_done", want.script_done, got.script_done);
      compare_field("script_running", want.script_running, got.script_running);
      results++;
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [CmdW-1:0]     s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_we_i;
  logic [CntW-1:0]     cfg_wdata_i;

  tick_scoreboard sb = new();
  int unsigned    n_sent      = 0;
  int unsigned    burst_left  = 0;
  int unsigned    quiet_count = 0;
  bit             hold_req    = 1'b0;

  scripted_stimulus_sequencer_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog: nothing moved on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_count <= 0;
    end else if (quiet_count >= WdogLimit) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet_count);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  // result side: check accepted items, stall in bursts, long hold on request
  initial begin : result_sink
    int unsigned stall_left, ready_left, hold_left;
    bit          nxt;
    stall_left = 0;
    ready_left = 0;
    hold_left  = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_tick(out_item_t'(m_axis_tdata));
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt = 1'b0;
      end else if (ready_left > 0) begin
        ready_left--;
        nxt = 1'b1;
      end else begin
        ready_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(1, 24);
        stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                 : $urandom_range(0, 5);
        nxt = 1'b1;
      end
      m_axis_tready <= nxt;
    end
  end

  function automatic in_item_t rand_payload();
    in_item_t d;
    d     = {$urandom, $urandom, $urandom};
    d.pad = 1'b0;
    return d;
  endfunction

  function automatic logic [ValW-1:0] pick_value();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'h0001;
      2:       return 16'h0002;
      3:       return 16'hFFFF;
      default: return $urandom_range(0, 16'hFFFF);
    endcase
  endfunction

  function automatic in_item_t step_item(int idx, kind_e k, logic [AmtW-1:0] amt,
                                         logic [BtnW-1:0] btn, logic [DirW-1:0] dr,
                                         logic [KeyW-1:0] key, bit hv, logic [ValW-1:0] val);
    in_item_t d;
    d                = rand_payload();
    d.step_index     = idx[IdxW-1:0];
    d.step_kind      = k;
    d.step_amount    = amt;
    d.step_buttons   = btn;
    d.step_stick_dir = dr;
    d.step_key       = key;
    d.step_has_value = hv;
    d.step_value     = val;
    return d;
  endfunction

  // random step, weighted towards short waits and timeouts so scripts move on
  function automatic in_item_t rand_step(int idx);
    in_item_t d;
    int       r;
    d            = rand_payload();
    d.step_index = idx[IdxW-1:0];
    r            = $urandom_range(0, 99);
    if (r < 20)      d.step_kind = K_WAIT;
    else if (r < 35) d.step_kind = K_PRESS;
    else if (r < 50) d.step_kind = K_STICK;
    else if (r < 63) d.step_kind = K_WAITEV;
    else if (r < 76) d.step_kind = K_PRESSUNTIL;
    else if (r < 86) d.step_kind = K_SETPERIOD;
    else if (r < 96) d.step_kind = K_SETTIMEOUT;
    else             d.step_kind = K_NOP;
    case (d.step_kind)
      K_WAIT: begin
        if ($urandom_range(0, 19) != 0) d.step_amount = $urandom_range(0, 3);
      end
      K_SETPERIOD: begin
        case ($urandom_range(0, 5))
          0:       d.step_amount = '0;
          1:       d.step_amount = PeriodMax;
          2:       d.step_amount = PeriodMax + 1'b1;
          3:       ;
          default: d.step_amount = $urandom_range(1, 4);
        endcase
      end
      K_SETTIMEOUT: begin
        case ($urandom_range(0, 7))
          0:       d.step_amount = '0;
          1:       d.step_amount = LimitMax;
          2:       ;
          default: d.step_amount = $urandom_range(1, 8);
        endcase
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) != 0) d.step_key = $urandom_range(0, 3);
    d.step_value = pick_value();
    return d;
  endfunction

  // events mostly aimed at the step the script waits on
  function automatic in_item_t event_item();
    in_item_t        d;
    logic [KeyW-1:0] k;
    logic [ValW-1:0] v;
    d = rand_payload();
    if (sb.peek_step(k, v) && $urandom_range(0, 3) != 0) begin
      d.event_key = k;
      if ($urandom_range(0, 3) != 0) d.event_value = v;
    end else begin
      if ($urandom_range(0, 1) == 0) d.event_key = $urandom_range(0, 3);
      d.event_value = pick_value();
    end
    return d;
  endfunction

  task automatic push_item(input cmd_e c, input in_item_t d);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_item(c, d);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 6);
    end
  endtask

  // register write only once the block has drained
  task automatic set_count(input logic [CntW-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    sb.set_steps(v);
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    in_item_t        d;
    int              i, j, k, r, sel, nload, phase;
    logic [CntW-1:0] n;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_LOAD;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    rst_ni        <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle: nothing loaded, count zero, arm must not start anything
    push_item(CMD_TICK, rand_payload());
    push_item(CMD_ARM, rand_payload());
    d             = rand_payload();
    d.event_key   = 4'hF;
    d.event_value = 16'h0000;
    push_item(CMD_EVENT, d);
    push_item(CMD_TICK, rand_payload());

    // every slot written once, so any count reads loaded steps only
    for (i = 0; i < TableDepth; i++) push_item(CMD_LOAD, rand_step(i));

    // directed script: stick override, unknown dir, nop step, saturation,
    // zero timeout, value-form press-until
    push_item(CMD_LOAD, step_item(0, K_PRESS, 0, 16'hFFFF, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(1, K_STICK, 0, 0, DIR_UP, 0, 0, 0));
    push_item(CMD_LOAD, step_item(2, K_STICK, 0, 0, DIR_LEFT, 0, 0, 0));
    push_item(CMD_LOAD, step_item(3, K_WAIT, 1, 0, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(4, K_STICK, 0, 0, DIR_BOGUS, 0, 0, 0));
    push_item(CMD_LOAD, step_item(5, K_PRESS, 0, 16'h0001, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(6, K_NOP, 24'hFFFFFF, 0, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(7, K_SETPERIOD, 24'hFFFFFF, 0, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(8, K_SETTIMEOUT, 0, 0, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(9, K_WAITEV, 0, 16'h00FF, DIR_NONE, 4'd3, 0, 0));
    push_item(CMD_LOAD, step_item(10, K_SETTIMEOUT, 24'hFFFFFF, 0, DIR_NONE, 0, 0, 0));
    push_item(CMD_LOAD, step_item(11, K_PRESSUNTIL, 0, 16'h8000, DIR_NONE, 4'hF, 1,
                                  16'hFFFF));
    push_item(CMD_LOAD, step_item(12, K_STICK, 0, 0, DIR_DOWN, 0, 0, 0));
    push_item(CMD_LOAD, step_item(13, K_STICK, 0, 0, DIR_RIGHT, 0, 0, 0));
    set_count(14);
    push_item(CMD_ARM, rand_payload());
    repeat (3) push_item(CMD_TICK, rand_payload());
    d             = rand_payload();
    d.event_key   = 4'hF;
    d.event_value = 16'hFFFF;
    push_item(CMD_EVENT, d);
    repeat (3) push_item(CMD_TICK, rand_payload());

    // random scripts; some phases change the count without re-arming
    phase = 0;
    while (n_sent < ItemTarget) begin
      phase++;
      sel = $urandom_range(0, 9);
      if (phase == 1 || sel == 1) n = 9'd256;
      else if (phase == 2)        n = 9'd1;
      else if (sel == 0)          n = 9'd0;
      else if (sel == 2)          n = 9'h1FF;
      else                        n = $urandom_range(1, 20);
      nload = (n > 24) ? $urandom_range(0, 6) : int'(n);
      for (i = 0; i < nload; i++) push_item(CMD_LOAD, rand_step(i));
      set_count(n);
      if (phase < 3 || $urandom_range(0, 4) != 0) push_item(CMD_ARM, rand_payload());
      if (phase == 3) begin
        // receiver holds off while ticks keep coming, so the input backs up
        hold_req   = 1'b1;
        burst_left = 120;
      end
      k = $urandom_range(25, 60);
      for (j = 0; j < k; j++) begin
        r = $urandom_range(0, 99);
        if (r < 62)      push_item(CMD_TICK, rand_payload());
        else if (r < 90) push_item(CMD_EVENT, event_item());
        else if (r < 94) push_item(CMD_ARM, rand_payload());
        else             push_item(CMD_LOAD, rand_step($urandom_range(0, TableDepth - 1)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    $display("Sent %0d items over %0d script phases; %0d tick results checked.",
             n_sent, phase, sb.results);
    $display("Waits met: %0d, waits timed out: %0d, scripts finished: %0d, mismatches: %0d.",
             sb.n_met, sb.n_timeout, sb.n_finished, sb.errors);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
